// ----- hw/rtl/sre_pkg.sv -----
package sre_pkg;

  localparam int DIGIT_W = 6;
  localparam int VARINT_W = 5;
  localparam int COORD_W = 12;
  localparam int ZZ_W = COORD_W + 1;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int PHASES = 6;

  // register indexes, byte address is 4 * index
  typedef enum logic [2:0] {
    REG_PAGE   = 3'd0,
    REG_STYLE  = 3'd1,
    REG_LAYER  = 3'd2,
    REG_WIDTH  = 3'd3,
    REG_COLOR  = 3'd4,
    REG_OFFSET = 3'd5,
    REG_MARK   = 3'd6
  } reg_idx_t;

  localparam logic [2:0] STYLE_STROKE = 3'd0;
  localparam logic [2:0] STYLE_COLLECTION = 3'd1;

  // output phases of one job, sent from lowest to highest set bit
  localparam logic [PHASES-1:0] PH_ERR = 6'b000001;
  localparam logic [PHASES-1:0] PH_HDR = 6'b000010;
  localparam logic [PHASES-1:0] PH_PT  = 6'b000100;
  localparam logic [PHASES-1:0] PH_RAW = 6'b001000;
  localparam logic [PHASES-1:0] PH_VX  = 6'b010000;
  localparam logic [PHASES-1:0] PH_VY  = 6'b100000;

  typedef struct packed {
    logic [11:0] page_number;
    logic [2:0]  line_style;
    logic [2:0]  layer_number;
    logic [6:0]  line_width;
    logic [15:0] line_color;
    logic [7:0]  digit_offset;
    logic [7:0]  record_mark;
  } cfg_t;

  typedef struct packed {
    logic [PHASES-1:0]  mask;
    logic [COORD_W-1:0] sx;
    logic [COORD_W-1:0] sy;
    logic [COORD_W-1:0] ex;
    logic [COORD_W-1:0] ey;
    logic [ZZ_W-1:0]    zx;
    logic [ZZ_W-1:0]    zy;
    logic [1:0]         nx;
    logic [1:0]         ny;
  } job_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       run_last;
    logic       style_error;
  } res_t;

endpackage

// ----- hw/rtl/sre_regs.sv -----
module sre_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sre_pkg::ADDR_W-1:0] paddr,
  input  logic [sre_pkg::DATA_W-1:0] pwdata,
  output logic [sre_pkg::DATA_W-1:0] prdata,
  output sre_pkg::cfg_t              cfg
);

  sre_pkg::reg_idx_t idx;
  logic              wr;

  assign idx = sre_pkg::reg_idx_t'(paddr[4:2]);
  assign wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.page_number <= 12'd0;
      cfg.line_style <= sre_pkg::STYLE_STROKE;
      cfg.layer_number <= 3'd0;
      cfg.line_width <= 7'd1;
      cfg.line_color <= 16'hFFFF;
      cfg.digit_offset <= 8'd48;
      cfg.record_mark <= 8'd46;
    end else if (wr) begin
      case (idx)
        sre_pkg::REG_PAGE:   cfg.page_number <= pwdata[11:0];
        sre_pkg::REG_STYLE:  cfg.line_style <= pwdata[2:0];
        sre_pkg::REG_LAYER:  cfg.layer_number <= pwdata[2:0];
        sre_pkg::REG_WIDTH:  cfg.line_width <= pwdata[6:0];
        sre_pkg::REG_COLOR:  cfg.line_color <= pwdata[15:0];
        sre_pkg::REG_OFFSET: cfg.digit_offset <= pwdata[7:0];
        sre_pkg::REG_MARK:   cfg.record_mark <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      sre_pkg::REG_PAGE:   prdata = 32'(cfg.page_number);
      sre_pkg::REG_STYLE:  prdata = 32'(cfg.line_style);
      sre_pkg::REG_LAYER:  prdata = 32'(cfg.layer_number);
      sre_pkg::REG_WIDTH:  prdata = 32'(cfg.line_width);
      sre_pkg::REG_COLOR:  prdata = 32'(cfg.line_color);
      sre_pkg::REG_OFFSET: prdata = 32'(cfg.digit_offset);
      sre_pkg::REG_MARK:   prdata = 32'(cfg.record_mark);
      default:             prdata = '0;
    endcase
  end

endmodule

// ----- hw/rtl/sre_front.sv -----
module sre_front (
  input  logic                        clk,
  input  logic                        rst,
  input  sre_pkg::cfg_t               cfg,
  input  logic                        push,
  input  logic                        jq_full,
  input  logic [sre_pkg::COORD_W-1:0] start_x,
  input  logic [sre_pkg::COORD_W-1:0] start_y,
  input  logic [sre_pkg::COORD_W-1:0] end_x,
  input  logic [sre_pkg::COORD_W-1:0] end_y,
  input  logic                        first_segment,
  output logic                        job_push,
  output sre_pkg::job_t               job
);

  logic [sre_pkg::COORD_W-1:0] prev_x;
  logic [sre_pkg::COORD_W-1:0] prev_y;
  logic [sre_pkg::COORD_W-1:0] ref_x;
  logic [sre_pkg::COORD_W-1:0] ref_y;
  logic                        accept;
  logic                        err;
  logic                        stroke;
  logic                        moved;

  function automatic logic [sre_pkg::ZZ_W-1:0] zigzag(
    input logic [sre_pkg::COORD_W-1:0] to,
    input logic [sre_pkg::COORD_W-1:0] from
  );
    logic [sre_pkg::ZZ_W-1:0] r;
    if (to >= from) begin
      r = {to - from, 1'b0};
    end else begin
      r = {from - to, 1'b0} - 13'd1;
    end
    return r;
  endfunction

  function automatic logic [1:0] varint_len(input logic [sre_pkg::ZZ_W-1:0] z);
    logic [1:0] n;
    if (z < 13'd32) begin
      n = 2'd1;
    end else if (z < 13'd1024) begin
      n = 2'd2;
    end else begin
      n = 2'd3;
    end
    return n;
  endfunction

  assign err = cfg.line_style > sre_pkg::STYLE_COLLECTION;
  assign stroke = cfg.line_style == sre_pkg::STYLE_STROKE;
  assign ref_x = first_segment ? start_x : prev_x;
  assign ref_y = first_segment ? start_y : prev_y;
  assign moved = (end_x != ref_x) || (end_y != ref_y);
  assign accept = push & ~jq_full;

  always_comb begin
    job.mask = '0;
    if (err) begin
      job.mask = sre_pkg::PH_ERR;
    end else begin
      if (first_segment) begin
        job.mask = job.mask | sre_pkg::PH_HDR;
      end
      if (!stroke) begin
        job.mask = job.mask | sre_pkg::PH_RAW;
      end else begin
        if (first_segment) begin
          job.mask = job.mask | sre_pkg::PH_PT;
        end
        if (moved) begin
          job.mask = job.mask | sre_pkg::PH_VX | sre_pkg::PH_VY;
        end
      end
    end
    job.sx = start_x;
    job.sy = start_y;
    job.ex = end_x;
    job.ey = end_y;
    job.zx = zigzag(end_x, ref_x);
    job.zy = zigzag(end_y, ref_y);
    job.nx = varint_len(job.zx);
    job.ny = varint_len(job.zy);
  end

  // a job with an empty mask (a stationary stroke segment that opens no record) is not pushed
  assign job_push = accept & (job.mask != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_x <= '0;
      prev_y <= '0;
    end else if (accept && !err) begin
      prev_x <= end_x;
      prev_y <= end_y;
    end
  end

endmodule

// ----- hw/rtl/sre_job_queue.sv -----
module sre_job_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  sre_pkg::job_t wr_job,
  output logic          full,
  input  logic          rd_en,
  output logic          valid,
  output sre_pkg::job_t rd_job
);

  sre_pkg::job_t q [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic          do_wr;
  logic          do_rd;

  assign full = count == 2'd2;
  assign valid = count != 2'd0;
  assign do_wr = wr_en & ~full;
  assign do_rd = rd_en & valid;
  assign rd_job = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      q[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_wr) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_rd) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end

endmodule

// ----- hw/rtl/sre_back.sv -----
module sre_back (
  input  logic          clk,
  input  logic          rst,
  input  sre_pkg::cfg_t cfg,
  input  logic          jq_valid,
  input  sre_pkg::job_t jq_job,
  output logic          jq_take,
  input  logic          pop,
  output logic          empty,
  output logic [7:0]    out_char,
  output logic          run_last,
  output logic          style_error
);

  sre_pkg::job_t              job;
  logic                       busy;
  logic [sre_pkg::PHASES-1:0] rem;
  logic [sre_pkg::PHASES-1:0] cur;
  logic [sre_pkg::PHASES-1:0] rem_next;
  logic [2:0]                 cnt;
  logic [2:0]                 cnt_end;
  logic                       phase_done;
  logic                       produce;
  logic                       last;
  logic [sre_pkg::DIGIT_W-1:0] digit;
  logic [5:0]                 width_digit;
  logic [sre_pkg::ZZ_W-1:0]   z;
  logic [1:0]                 n;
  logic [sre_pkg::VARINT_W-1:0] payload;
  logic                       cont;
  sre_pkg::res_t              res;

  sre_pkg::res_t              oq [2];
  logic                       oq_wr_ptr;
  logic                       oq_rd_ptr;
  logic [1:0]                 oq_count;
  logic                       oq_full;
  logic                       oq_pop;

  assign cur = rem & (~rem + 6'd1);
  assign rem_next = rem & ~cur;
  assign z = (cur == sre_pkg::PH_VX) ? job.zx : job.zy;
  assign n = (cur == sre_pkg::PH_VX) ? job.nx : job.ny;

  always_comb begin
    case (cur)
      sre_pkg::PH_ERR: cnt_end = 3'd0;
      sre_pkg::PH_HDR: cnt_end = 3'd7;
      sre_pkg::PH_PT:  cnt_end = 3'd3;
      sre_pkg::PH_RAW: cnt_end = 3'd7;
      sre_pkg::PH_VX:  cnt_end = 3'(n) - 3'd1;
      sre_pkg::PH_VY:  cnt_end = 3'(n) - 3'd1;
      default:         cnt_end = 3'd0;
    endcase
  end

  assign phase_done = cnt == cnt_end;
  assign produce = busy & ~oq_full;
  assign last = phase_done & (rem_next == '0);
  assign jq_take = jq_valid & (~busy | (produce & last));

  // width minus one, saturated to one digit, zero width saturates too
  always_comb begin
    if (cfg.line_width == 7'd0 || cfg.line_width > 7'd64) begin
      width_digit = 6'h3F;
    end else begin
      width_digit = 6'(cfg.line_width - 7'd1);
    end
  end

  always_comb begin
    case (cnt)
      3'd0:    payload = z[4:0];
      3'd1:    payload = z[9:5];
      default: payload = 5'(z[12:10]);
    endcase
    cont = 3'(n) > (cnt + 3'd1);
  end

  always_comb begin
    digit = '0;
    case (cur)
      sre_pkg::PH_HDR: begin
        case (cnt)
          3'd1:    digit = cfg.page_number[5:0];
          3'd2:    digit = cfg.page_number[11:6];
          3'd3:    digit = {cfg.layer_number, cfg.line_style};
          3'd4:    digit = width_digit;
          3'd5:    digit = cfg.line_color[5:0];
          3'd6:    digit = cfg.line_color[11:6];
          3'd7:    digit = 6'(cfg.line_color[15:12]);
          default: digit = '0;
        endcase
      end
      sre_pkg::PH_PT, sre_pkg::PH_RAW: begin
        case (cnt)
          3'd0:    digit = job.sx[5:0];
          3'd1:    digit = job.sx[11:6];
          3'd2:    digit = job.sy[5:0];
          3'd3:    digit = job.sy[11:6];
          3'd4:    digit = job.ex[5:0];
          3'd5:    digit = job.ex[11:6];
          3'd6:    digit = job.ey[5:0];
          3'd7:    digit = job.ey[11:6];
          default: digit = '0;
        endcase
      end
      sre_pkg::PH_VX, sre_pkg::PH_VY: digit = {cont, payload};
      default: digit = '0;
    endcase
  end

  always_comb begin
    res.run_last = last;
    res.style_error = 1'b0;
    res.out_char = 8'(cfg.digit_offset + {2'b00, digit});
    case (cur)
      sre_pkg::PH_ERR: begin
        res.out_char = 8'd0;
        res.style_error = 1'b1;
      end
      sre_pkg::PH_HDR: begin
        if (cnt == 3'd0) begin
          res.out_char = cfg.record_mark;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (jq_take) begin
      job <= jq_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rem <= '0;
      cnt <= 3'd0;
    end else if (jq_take) begin
      busy <= 1'b1;
      rem <= jq_job.mask;
      cnt <= 3'd0;
    end else if (produce) begin
      if (last) begin
        busy <= 1'b0;
        rem <= '0;
        cnt <= 3'd0;
      end else if (phase_done) begin
        rem <= rem_next;
        cnt <= 3'd0;
      end else begin
        cnt <= cnt + 3'd1;
      end
    end
  end

  // result queue, two beats deep
  assign oq_full = oq_count == 2'd2;
  assign empty = oq_count == 2'd0;
  assign oq_pop = pop & ~empty;
  assign out_char = oq[oq_rd_ptr].out_char;
  assign run_last = oq[oq_rd_ptr].run_last;
  assign style_error = oq[oq_rd_ptr].style_error;

  always_ff @(posedge clk) begin
    if (produce) begin
      oq[oq_wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wr_ptr <= 1'b0;
      oq_rd_ptr <= 1'b0;
      oq_count <= 2'd0;
    end else begin
      if (produce) begin
        oq_wr_ptr <= ~oq_wr_ptr;
      end
      if (oq_pop) begin
        oq_rd_ptr <= ~oq_rd_ptr;
      end
      oq_count <= oq_count + {1'b0, produce} - {1'b0, oq_pop};
    end
  end

endmodule

// ----- hw/rtl/stroke_record_encoder_unit.sv -----
// Stroke record encoder. Segments are pushed one per clock while full is
// low; the front end classifies each one, computes its zig-zag deltas
// against the current point and queues a job in a two-entry job queue.
// The back end sends one character beat per clock from the job while the
// result queue has room; a segment has 2 to 6 characters for a moving
// stroke segment, 8 extra for a record header, 4 for the start point, 8
// for a collection segment, 1 for an unsupported style and 0 for a
// stationary segment. The back end's one-character-per-cycle output sets
// the sustained rate. Results leave through a two-beat queue, run_last
// marks the last character of a segment. The user must write registers
// over the APB port only while the block is idle; it does not enforce this.
module stroke_record_encoder_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sre_pkg::ADDR_W-1:0]  paddr,
  input  logic [sre_pkg::DATA_W-1:0]  pwdata,
  output logic [sre_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  input  logic [sre_pkg::COORD_W-1:0] start_x,
  input  logic [sre_pkg::COORD_W-1:0] start_y,
  input  logic [sre_pkg::COORD_W-1:0] end_x,
  input  logic [sre_pkg::COORD_W-1:0] end_y,
  input  logic                        first_segment,
  input  logic                        push,
  output logic                        full,
  output logic [7:0]                  out_char,
  output logic                        run_last,
  output logic                        style_error,
  output logic                        empty,
  input  logic                        pop
);

  sre_pkg::cfg_t cfg;
  sre_pkg::job_t fe_job;
  sre_pkg::job_t jq_job;
  logic          fe_push;
  logic          jq_full;
  logic          jq_valid;
  logic          jq_take;

  assign pready = 1'b1;
  assign full = jq_full;

  sre_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  sre_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .push          (push),
    .jq_full       (jq_full),
    .start_x       (start_x),
    .start_y       (start_y),
    .end_x         (end_x),
    .end_y         (end_y),
    .first_segment (first_segment),
    .job_push      (fe_push),
    .job           (fe_job)
  );

  sre_job_queue u_job_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (fe_push),
    .wr_job (fe_job),
    .full   (jq_full),
    .rd_en  (jq_take),
    .valid  (jq_valid),
    .rd_job (jq_job)
  );

  sre_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .jq_valid    (jq_valid),
    .jq_job      (jq_job),
    .jq_take     (jq_take),
    .pop         (pop),
    .empty       (empty),
    .out_char    (out_char),
    .run_last    (run_last),
    .style_error (style_error)
  );

endmodule

// ----- tb/sv/stroke_record_checker.sv -----
`timescale 1ns / 100ps

module stroke_record_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [sre_pkg::ADDR_W-1:0]  paddr,
  input  logic [sre_pkg::DATA_W-1:0]  pwdata,
  input  logic [sre_pkg::COORD_W-1:0] start_x,
  input  logic [sre_pkg::COORD_W-1:0] start_y,
  input  logic [sre_pkg::COORD_W-1:0] end_x,
  input  logic [sre_pkg::COORD_W-1:0] end_y,
  input  logic                        first_segment,
  input  logic                        push,
  input  logic                        full,
  input  logic [7:0]                  out_char,
  input  logic                        run_last,
  input  logic                        style_error,
  input  logic                        empty,
  input  logic                        pop,
  input  logic                        drained,
  output int                          pending,
  output int                          errors,
  output int                          segments,
  output int                          beats
);

  localparam int PAGE_DIGITS = 2;
  localparam int COORD_DIGITS = 2;
  localparam int COLOR_DIGITS = 3;
  localparam int MAX_CHARS = 18;

  sre_pkg::cfg_t cfg;
  logic [sre_pkg::COORD_W-1:0] cur_x;
  logic [sre_pkg::COORD_W-1:0] cur_y;
  sre_pkg::res_t expected_chars[$];
  logic [7:0] seg_chars[$];
  sre_pkg::res_t want;
  logic leftover_seen;

  task automatic report(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  function automatic void add_digits(input int unsigned value, input int n);
    int unsigned limit;
    int unsigned digit;
    logic [7:0] ch;
    limit = (1 << (n * sre_pkg::DIGIT_W)) - 1;
    if (value > limit) value = limit;
    for (int i = 0; i < n; i++) begin
      digit = (value >> (i * sre_pkg::DIGIT_W)) & ((1 << sre_pkg::DIGIT_W) - 1);
      ch = 8'(cfg.digit_offset + digit);
      seg_chars.push_back(ch);
    end
  endfunction

  function automatic void add_varint(input int unsigned value);
    int unsigned part;
    logic [7:0] ch;
    logic more;
    more = 1'b1;
    while (more) begin
      part = value & ((1 << sre_pkg::VARINT_W) - 1);
      value = value >> sre_pkg::VARINT_W;
      more = (value != 0);
      if (more) part = part | (1 << sre_pkg::VARINT_W);
      ch = 8'(cfg.digit_offset + part);
      seg_chars.push_back(ch);
    end
  endfunction

  function automatic int unsigned zigzag_delta(input int unsigned dest, input int unsigned orig);
    if (dest >= orig) return (dest - orig) << 1;
    return ((orig - dest) << 1) - 1;
  endfunction

  function automatic void encode_segment(input logic [11:0] sx, input logic [11:0] sy,
                                         input logic [11:0] ex, input logic [11:0] ey,
                                         input logic first);
    sre_pkg::res_t r;
    int unsigned width_m1;
    int n;
    seg_chars.delete();
    if (cfg.line_style > sre_pkg::STYLE_COLLECTION) begin
      r.out_char = 8'd0;
      r.run_last = 1'b1;
      r.style_error = 1'b1;
      expected_chars.push_back(r);
      return;
    end
    if (first) begin
      seg_chars.push_back(cfg.record_mark);
      add_digits(cfg.page_number, PAGE_DIGITS);
      add_digits({cfg.layer_number, cfg.line_style}, 1);
      width_m1 = (cfg.line_width == 0) ? 32'hffff_ffff : cfg.line_width - 1;
      add_digits(width_m1, 1);
      add_digits(cfg.line_color, COLOR_DIGITS);
    end
    if (cfg.line_style == sre_pkg::STYLE_STROKE) begin
      if (first) begin
        add_digits(sx, COORD_DIGITS);
        add_digits(sy, COORD_DIGITS);
        cur_x = sx;
        cur_y = sy;
      end
      if (ex != cur_x || ey != cur_y) begin
        add_varint(zigzag_delta(ex, cur_x));
        add_varint(zigzag_delta(ey, cur_y));
      end
    end else begin
      add_digits(sx, COORD_DIGITS);
      add_digits(sy, COORD_DIGITS);
      add_digits(ex, COORD_DIGITS);
      add_digits(ey, COORD_DIGITS);
    end
    cur_x = ex;
    cur_y = ey;
    n = (seg_chars.size() > MAX_CHARS) ? MAX_CHARS : seg_chars.size();
    for (int i = 0; i < n; i++) begin
      r.out_char = seg_chars[i];
      r.run_last = (i == n - 1);
      r.style_error = 1'b0;
      expected_chars.push_back(r);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      cfg.page_number = 12'd0;
      cfg.line_style = sre_pkg::STYLE_STROKE;
      cfg.layer_number = 3'd0;
      cfg.line_width = 7'd1;
      cfg.line_color = 16'hffff;
      cfg.digit_offset = 8'd48;
      cfg.record_mark = 8'd46;
      cur_x = '0;
      cur_y = '0;
      expected_chars.delete();
      leftover_seen = 1'b0;
      pending <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          sre_pkg::REG_PAGE:   cfg.page_number = pwdata[11:0];
          sre_pkg::REG_STYLE:  cfg.line_style = pwdata[2:0];
          sre_pkg::REG_LAYER:  cfg.layer_number = pwdata[2:0];
          sre_pkg::REG_WIDTH:  cfg.line_width = pwdata[6:0];
          sre_pkg::REG_COLOR:  cfg.line_color = pwdata[15:0];
          sre_pkg::REG_OFFSET: cfg.digit_offset = pwdata[7:0];
          sre_pkg::REG_MARK:   cfg.record_mark = pwdata[7:0];
          default: ;
        endcase
      end
      if (pop && !empty) begin
        beats++;
        if (expected_chars.size() == 0) begin
          report($sformatf("beat %0d arrived with nothing expected", beats));
        end else begin
          want = expected_chars.pop_front();
          if (out_char !== want.out_char)
            report($sformatf("beat %0d out_char %h, want %h", beats, out_char, want.out_char));
          if (run_last !== want.run_last)
            report($sformatf("beat %0d run_last %b, want %b", beats, run_last, want.run_last));
          if (style_error !== want.style_error)
            report($sformatf("beat %0d style_error %b, want %b", beats, style_error,
                             want.style_error));
        end
      end
      if (push && !full) begin
        encode_segment(start_x, start_y, end_x, end_y, first_segment);
        segments++;
      end
      if (drained && !leftover_seen && expected_chars.size() != 0) begin
        leftover_seen = 1'b1;
        report($sformatf("%0d expected beats never arrived", expected_chars.size()));
      end
      pending <= expected_chars.size();
    end
  end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [sre_pkg::ADDR_W-1:0] paddr;
  logic [sre_pkg::DATA_W-1:0] pwdata;
  logic [sre_pkg::DATA_W-1:0] prdata;
  logic pready;
  logic [sre_pkg::COORD_W-1:0] start_x;
  logic [sre_pkg::COORD_W-1:0] start_y;
  logic [sre_pkg::COORD_W-1:0] end_x;
  logic [sre_pkg::COORD_W-1:0] end_y;
  logic first_segment;
  logic push;
  logic full;
  logic [7:0] out_char;
  logic run_last;
  logic style_error;
  logic empty;
  logic pop;
  logic drained;

  int pending;
  int errors;
  int segments;
  int beats;
  int cycles;
  int send_idle;
  int recv_idle;
  int rx_hold;
  logic [11:0] pen_x;
  logic [11:0] pen_y;

  always #5 clk = ~clk;

  stroke_record_encoder_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .start_x       (start_x),
    .start_y       (start_y),
    .end_x         (end_x),
    .end_y         (end_y),
    .first_segment (first_segment),
    .push          (push),
    .full          (full),
    .out_char      (out_char),
    .run_last      (run_last),
    .style_error   (style_error),
    .empty         (empty),
    .pop           (pop)
  );

  stroke_record_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .start_x       (start_x),
    .start_y       (start_y),
    .end_x         (end_x),
    .end_y         (end_y),
    .first_segment (first_segment),
    .push          (push),
    .full          (full),
    .out_char      (out_char),
    .run_last      (run_last),
    .style_error   (style_error),
    .empty         (empty),
    .pop           (pop),
    .drained       (drained),
    .pending       (pending),
    .errors        (errors),
    .segments      (segments),
    .beats         (beats)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  // receiver, with an optional long hold-off
  always @(posedge clk) begin
    if (rx_hold > 0) begin
      rx_hold--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic apb_write(input sre_pkg::reg_idx_t idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic offer(input logic [11:0] sx, input logic [11:0] sy,
                       input logic [11:0] ex, input logic [11:0] ey, input logic first);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    start_x <= sx;
    start_y <= sy;
    end_x <= ex;
    end_y <= ey;
    first_segment <= first;
    @(posedge clk);
    while (full) @(posedge clk);
    pen_x = ex;
    pen_y = ey;
  endtask

  // stop sending and wait until every expected beat is out
  task automatic settle();
    push <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [11:0] pick_coord();
    case ($urandom_range(3))
      0: return 12'h000;
      1: return 12'hfff;
      default: return 12'($urandom);
    endcase
  endfunction

  function automatic logic [11:0] step_coord(input logic [11:0] c);
    int v;
    int cv;
    cv = c;
    v = $urandom_range(64);
    v = cv + v - 32;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return 12'(v);
  endfunction

  task automatic program_config(input int k);
    logic [31:0] width;
    logic [31:0] offset;
    case (k)
      0: width = 1;
      1: width = 64;
      2: width = 0;
      3: width = 127;
      default: width = $urandom_range(64, 1);
    endcase
    case (k)
      0: offset = 48;
      1: offset = 192;
      2: offset = 0;
      3: offset = 255;
      default: offset = $urandom_range(192);
    endcase
    apb_write(sre_pkg::REG_PAGE, (k == 1) ? 4095 : (k == 3) ? 0 : $urandom_range(4095));
    apb_write(sre_pkg::REG_STYLE, (k % 2 == 0) ? sre_pkg::STYLE_STROKE
                                              : sre_pkg::STYLE_COLLECTION);
    apb_write(sre_pkg::REG_LAYER, (k == 1) ? 7 : (k == 3) ? 0 : $urandom_range(7));
    apb_write(sre_pkg::REG_WIDTH, width);
    apb_write(sre_pkg::REG_COLOR, (k == 0) ? 0 : (k == 1) ? 65535 : $urandom_range(65535));
    apb_write(sre_pkg::REG_OFFSET, offset);
    apb_write(sre_pkg::REG_MARK, (k == 2) ? 0 : (k == 3) ? 255 : $urandom_range(255));
  endtask

  // mostly chained segments, some fresh records, some noise
  task automatic random_items(input int count);
    int r;
    logic [11:0] sx;
    logic [11:0] sy;
    logic [11:0] ex;
    logic [11:0] ey;
    logic first;
    repeat (count) begin
      r = $urandom_range(99);
      if (r >= 90) begin
        sx = 12'($urandom);
        sy = 12'($urandom);
        ex = 12'($urandom);
        ey = 12'($urandom);
        first = 1'($urandom_range(1));
      end else begin
        first = (r < 12);
        sx = first ? pick_coord() : pen_x;
        sy = first ? pick_coord() : pen_y;
        r = $urandom_range(99);
        if (r < 10) begin
          ex = sx;
          ey = sy;
        end else if (r < 70) begin
          ex = step_coord(sx);
          ey = step_coord(sy);
        end else begin
          ex = pick_coord();
          ey = pick_coord();
        end
      end
      offer(sx, sy, ex, ey, first);
    end
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    start_x = '0;
    start_y = '0;
    end_x = '0;
    end_y = '0;
    first_segment = 1'b0;
    push = 1'b0;
    pop = 1'b0;
    drained = 1'b0;
    cycles = 0;
    rx_hold = 0;
    pen_x = '0;
    pen_y = '0;
    send_idle = 19;
    recv_idle = 54;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset settings: stroke from the reset point, stationary, extremes
    offer(12'd7, 12'd9, 12'd3, 12'd0, 1'b0);
    offer(12'd3, 12'd0, 12'd3, 12'd0, 1'b0);
    offer(12'hfff, 12'hfff, 12'h000, 12'h000, 1'b1);
    offer(12'h000, 12'h000, 12'hfff, 12'hfff, 1'b1);
    offer(12'hfff, 12'hfff, 12'hffe, 12'hfff, 1'b0);
    offer(12'hffe, 12'hfff, 12'hfff, 12'hfff, 1'b0);
    offer(12'd100, 12'd200, 12'd100, 12'd200, 1'b1);
    offer(12'd100, 12'd200, 12'd131, 12'd169, 1'b0);

    // collection style with the header fields at their extremes
    settle();
    apb_write(sre_pkg::REG_STYLE, sre_pkg::STYLE_COLLECTION);
    apb_write(sre_pkg::REG_PAGE, 4095);
    apb_write(sre_pkg::REG_LAYER, 7);
    apb_write(sre_pkg::REG_WIDTH, 64);
    apb_write(sre_pkg::REG_COLOR, 0);
    apb_write(sre_pkg::REG_OFFSET, 0);
    apb_write(sre_pkg::REG_MARK, 255);
    offer(12'h000, 12'hfff, 12'hfff, 12'h000, 1'b1);
    offer(12'hfff, 12'h000, 12'hfff, 12'h000, 1'b0);
    offer(12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom), 1'b0);

    // unsupported styles
    for (int st = 2; st < 8; st++) begin
      settle();
      apb_write(sre_pkg::REG_STYLE, st);
      offer(12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom), st[0]);
    end

    // width zero and above range, character wrap
    settle();
    apb_write(sre_pkg::REG_STYLE, sre_pkg::STYLE_STROKE);
    apb_write(sre_pkg::REG_WIDTH, 0);
    apb_write(sre_pkg::REG_OFFSET, 255);
    apb_write(sre_pkg::REG_MARK, 0);
    offer(pick_coord(), pick_coord(), pick_coord(), pick_coord(), 1'b1);
    settle();
    apb_write(sre_pkg::REG_WIDTH, 127);
    offer(pick_coord(), pick_coord(), pick_coord(), pick_coord(), 1'b1);
    offer(pen_x, pen_y, step_coord(pen_x), step_coord(pen_y), 1'b0);

    for (int p = 0; p < 3; p++) begin
      send_idle = (p == 0) ? 19 : (p == 1) ? 54 : 0;
      recv_idle = (p == 0) ? 54 : (p == 1) ? 19 : 0;
      for (int s = 0; s < 2; s++) begin
        settle();
        program_config(2 * p + s);
        if (p == 0 && s == 1) rx_hold = 400;
        random_items(65);
      end
    end

    settle();
    drained <= 1'b1;
    repeat (3) @(posedge clk);
    $display("covered %0d segments and %0d character beats over reset, edge and random settings",
             segments, beats);
    $display("stroke, collection and unsupported styles, three idle mixes, one long stall");
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
